FILE: src/tidt_pkg.sv
// Package for the transaction ID table: command and status codes,
// transfer payload structs, default sizes and the table_size register layout.
// No dependencies.
package tidt_pkg;

  // Default table geometry.
  localparam int unsigned DefaultDepth   = 16;
  localparam int unsigned DefaultIdWidth = 32;

  // The table_size configuration register.
  localparam int unsigned TableSizeW = 5;
  localparam logic [TableSizeW-1:0] TableSizeReset = 5'd16;

  // Command codes carried in the input transfer.
  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_ALLOC  = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_e;

  // Status codes returned in the output transfer.
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_COLLIDE   = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_e;

  // Input transfer payload.
  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] id_value;
  } in_t;

  // Output transfer payload.
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] id_out;
    logic [3:0]  slot_index;
    logic [4:0]  entry_count;
  } out_t;

endpackage

FILE: src/tidt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds the identifier words of the transaction ID table. No dependencies.
module tidt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: src/transaction_id_table_top.sv
// Top level of the transaction ID table.
// Depends on tidt_pkg (codes, payload structs) and tidt_ram (identifier storage).
//
// Usage:
// The block keeps DEPTH identifier slots; a slot that holds no identifier is free.
// One command arrives per input transfer (add, allocate a random candidate, remove)
// and each yields exactly one output transfer with status, identifier, slot and the
// number of occupied slots. A transfer happens at a clock edge where valid is high
// and stall is low. table_size is written through cfg_we_i/cfg_wdata_i; the user
// must write it only while the block is idle, the block itself does not enforce
// this. It limits the scan to min(table_size, DEPTH) slots from slot zero, each
// read once by the scan sequencer through the single RAM read port. A new command
// is taken only after the last one is committed. A command that fails without a
// scan (zero identifier, unknown code) goes straight to the commit step. in_stall_o
// is high while a command is in progress and while a finished result waits for a
// stalled receiver.
// A result waiting in the output register does not block the next command.
// Reset frees all slots at once (per-slot occupancy flops), clears the count and
// sets table_size to 16; no clearing pass is needed.
module transaction_id_table_top
  import tidt_pkg::*;
#(
  parameter int unsigned DEPTH    = DefaultDepth,
  parameter int unsigned ID_WIDTH = DefaultIdWidth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [TableSizeW-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_data_o
);

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned WinW = (CntW > TableSizeW) ? CntW : TableSizeW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  state_e                state_q, state_d;
  logic [1:0]            cmd_q, cmd_d;
  logic [ID_WIDTH-1:0]   id_q, id_d;
  logic [CntW-1:0]       win_q, win_d;
  logic [CntW-1:0]       rd_cnt_q, rd_cnt_d;
  logic                  cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0]       cmp_idx_q, cmp_idx_d;
  logic                  free_fnd_q, free_fnd_d;
  logic [IdxW-1:0]       free_idx_q, free_idx_d;
  logic                  hit_q, hit_d;
  logic [IdxW-1:0]       hit_idx_q, hit_idx_d;
  logic [DEPTH-1:0]      occ_q, occ_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [TableSizeW-1:0] table_size_q, table_size_d;
  logic                  out_vld_q, out_vld_d;
  out_t                  out_q, out_d;

  logic [ID_WIDTH-1:0]   id_in;
  logic [WinW-1:0]       ts_ext;
  logic [CntW-1:0]       win;
  logic                  ram_we;
  logic                  ram_re;
  logic [ID_WIDTH-1:0]   ram_rdata;

  status_e               res_status;
  logic [IdxW-1:0]       res_slot;
  logic                  res_wr;
  logic                  res_clr;
  logic [CntW-1:0]       count_next;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Incoming identifier reduced to the table width.
  assign id_in = ID_WIDTH'(in_data_i.id_value);

  // Scan window: table_size limited to the slot count.
  assign ts_ext = WinW'(table_size_q);
  assign win    = (ts_ext > WinW'(DEPTH)) ? CntW'(DEPTH) : CntW'(ts_ext);

  // Identifier storage, read once per scanned slot.
  tidt_ram #(
    .WIDTH(ID_WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(free_idx_q),
    .wdata_i(id_q),
    .re_i   (ram_re),
    .raddr_i(rd_cnt_q[IdxW-1:0]),
    .rdata_o(ram_rdata)
  );

  // Outcome of the command from the scan flags.
  always_comb begin
    res_status = STATUS_NOT_FOUND;
    res_slot   = '0;
    res_wr     = 1'b0;
    res_clr    = 1'b0;
    case (cmd_q)
      CMD_ADD: begin
        if (id_q != '0) begin
          if (free_fnd_q) begin
            res_status = STATUS_OK;
            res_slot   = free_idx_q;
            res_wr     = 1'b1;
          end else begin
            res_status = STATUS_FULL;
          end
        end
      end
      CMD_ALLOC: begin
        if (id_q == '0 || hit_q) begin
          res_status = STATUS_COLLIDE;
        end else if (free_fnd_q) begin
          res_status = STATUS_OK;
          res_slot   = free_idx_q;
          res_wr     = 1'b1;
        end else begin
          res_status = STATUS_FULL;
        end
      end
      CMD_REMOVE: begin
        if (hit_q) begin
          res_status = STATUS_OK;
          res_slot   = hit_idx_q;
          res_clr    = 1'b1;
        end
      end
      default: begin
        res_status = STATUS_NOT_FOUND;
      end
    endcase
  end

  // Occupied-slot count after the command, saturating at both ends.
  always_comb begin
    count_next = count_q;
    if (res_wr && count_q < CntW'(DEPTH)) begin
      count_next = count_q + 1'b1;
    end else if (res_clr && count_q != '0) begin
      count_next = count_q - 1'b1;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    id_d         = id_q;
    win_d        = win_q;
    rd_cnt_d     = rd_cnt_q;
    cmp_vld_d    = cmp_vld_q;
    cmp_idx_d    = cmp_idx_q;
    free_fnd_d   = free_fnd_q;
    free_idx_d   = free_idx_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    occ_d        = occ_q;
    count_d      = count_q;
    table_size_d = table_size_q;
    out_vld_d    = out_vld_q;
    out_d        = out_q;
    ram_re       = 1'b0;
    ram_we       = 1'b0;

    // Configuration write.
    if (cfg_we_i) begin
      table_size_d = cfg_wdata_i;
    end

    // Output register empties when its transfer completes.
    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d      = in_data_i.command;
          id_d       = id_in;
          win_d      = win;
          rd_cnt_d   = '0;
          cmp_vld_d  = 1'b0;
          free_fnd_d = 1'b0;
          hit_d      = 1'b0;
          if (id_in == '0 || !(in_data_i.command inside {CMD_ADD, CMD_ALLOC, CMD_REMOVE}))
          begin
            state_d = S_FINISH;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // Issue one read per cycle; compare the word read in the cycle before.
        if (rd_cnt_q < win_q) begin
          ram_re    = 1'b1;
          rd_cnt_d  = rd_cnt_q + 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_cnt_q[IdxW-1:0];
        end else begin
          cmp_vld_d = 1'b0;
          state_d   = S_FINISH;
        end
        if (cmp_vld_q) begin
          if (!occ_q[cmp_idx_q] && !free_fnd_q) begin
            free_fnd_d = 1'b1;
            free_idx_d = cmp_idx_q;
          end
          if (occ_q[cmp_idx_q] && ram_rdata == id_q && !hit_q) begin
            hit_d     = 1'b1;
            hit_idx_d = cmp_idx_q;
          end
        end
      end
      S_FINISH: begin
        // Commit and present the result once the output register is free.
        if (!out_vld_q || !out_stall_i) begin
          ram_we    = res_wr;
          count_d   = count_next;
          if (res_wr) begin
            occ_d[free_idx_q] = 1'b1;
          end
          if (res_clr) begin
            occ_d[hit_idx_q] = 1'b0;
          end
          out_vld_d         = 1'b1;
          out_d.status      = res_status;
          out_d.id_out      = (res_status == STATUS_OK) ? 32'(id_q) : 32'd0;
          out_d.slot_index  = 4'(res_slot);
          out_d.entry_count = 5'(count_next);
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cmd_q        <= '0;
      id_q         <= '0;
      win_q        <= '0;
      rd_cnt_q     <= '0;
      cmp_vld_q    <= 1'b0;
      cmp_idx_q    <= '0;
      free_fnd_q   <= 1'b0;
      free_idx_q   <= '0;
      hit_q        <= 1'b0;
      hit_idx_q    <= '0;
      occ_q        <= '0;
      count_q      <= '0;
      table_size_q <= TableSizeReset;
      out_vld_q    <= 1'b0;
      out_q        <= '0;
    end else begin
      state_q      <= state_d;
      cmd_q        <= cmd_d;
      id_q         <= id_d;
      win_q        <= win_d;
      rd_cnt_q     <= rd_cnt_d;
      cmp_vld_q    <= cmp_vld_d;
      cmp_idx_q    <= cmp_idx_d;
      free_fnd_q   <= free_fnd_d;
      free_idx_q   <= free_idx_d;
      hit_q        <= hit_d;
      hit_idx_q    <= hit_idx_d;
      occ_q        <= occ_d;
      count_q      <= count_d;
      table_size_q <= table_size_d;
      out_vld_q    <= out_vld_d;
      out_q        <= out_d;
    end
  end

  // The occupied count never exceeds the slot count.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("occupied count exceeds slot count");

  // After an input transfer the block is busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block not busy after input transfer");

  // The RAM is written only when committing into a free slot.
  a_write_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_FINISH) && !occ_q[free_idx_q])
    else $error("write into an occupied slot");

  // The read counter stays inside the window.
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (rd_cnt_q <= win_q))
    else $error("scan ran past the window");

  // A recorded hit always points at an occupied slot.
  a_hit_occupied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE && hit_q) |-> occ_q[hit_idx_q])
    else $error("hit recorded on a free slot");

endmodule

FILE: tb/sv/transaction_id_table_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for transaction_id_table_top: directed and random commands
// checked against a behavioral table model. Depends on tidt_pkg and the top level.
module transaction_id_table_top_tb;
  import tidt_pkg::*;

  localparam int unsigned Depth         = DefaultDepth;
  localparam logic [1:0]  CmdUnknown    = 2'd3;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned DrainCycles   = 40;
  localparam int unsigned PhaseItems    = 110;
  localparam int unsigned RandomPhases  = 8;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [TableSizeW-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_t                   in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_t                  out_data_o;

  // Table model state and the results it predicts.
  logic [31:0]           model_slots [Depth];
  int unsigned           model_count;
  int unsigned           model_table_size;
  out_t                  expected_results[$];

  // Commands waiting for the driver, and recent IDs used to provoke hits.
  in_t                   pending_commands[$];
  logic [31:0]           recent_ids[$];

  bit                    in_idle_on;
  bit                    out_idle_on;
  bit                    in_taken;
  int unsigned           in_gap_left;
  int unsigned           out_stall_left;
  int unsigned           quiet_cycles;
  int unsigned           error_count;
  int unsigned           add_weight;

  transaction_id_table_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // 10 ns clock.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Applies one command to the table model and returns the result it should give.
  function automatic out_t apply_command(in_t item);
    out_t        res;
    int unsigned span;
    int          hit;
    int          free_pos;
    res        = '0;
    res.status = STATUS_NOT_FOUND;
    span       = (model_table_size > Depth) ? Depth : model_table_size;
    hit        = -1;
    free_pos   = -1;
    for (int i = 0; i < span; i++) begin
      if (hit < 0 && model_slots[i] == item.id_value) hit = i;
      if (free_pos < 0 && model_slots[i] == '0) free_pos = i;
    end
    case (item.command)
      CMD_ADD, CMD_ALLOC: begin
        if (item.command == CMD_ADD && item.id_value == '0) begin
          res.status = STATUS_NOT_FOUND;
        end else if (item.command == CMD_ALLOC && (item.id_value == '0 || hit >= 0)) begin
          res.status = STATUS_COLLIDE;
        end else if (free_pos < 0) begin
          res.status = STATUS_FULL;
        end else begin
          model_slots[free_pos] = item.id_value;
          if (model_count < Depth) model_count++;
          res.status     = STATUS_OK;
          res.id_out     = item.id_value;
          res.slot_index = free_pos[3:0];
        end
      end
      CMD_REMOVE: begin
        if (item.id_value != '0 && hit >= 0) begin
          model_slots[hit] = '0;
          if (model_count > 0) model_count--;
          res.status     = STATUS_OK;
          res.id_out     = item.id_value;
          res.slot_index = hit[3:0];
        end
      end
      default: begin
        res.status = STATUS_NOT_FOUND;
      end
    endcase
    res.entry_count = model_count[4:0];
    return res;
  endfunction

  // Idle length: mostly none, sometimes a few cycles, now and then a long one.
  function automatic int unsigned idle_length(bit enabled);
    int unsigned r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Random command with IDs drawn so that hits on stored entries are common.
  function automatic in_t random_command();
    in_t         item;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < add_weight)            item.command = CMD_ADD;
    else if (r < add_weight + 30)  item.command = CMD_ALLOC;
    else if (r < 95)               item.command = CMD_REMOVE;
    else                           item.command = CmdUnknown;
    r = $urandom_range(0, 99);
    if (r < 8)                               item.id_value = '0;
    else if (r < 40)                         item.id_value = $urandom_range(1, 24);
    else if (r < 75 && recent_ids.size() > 0)
      item.id_value = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
    else if (r < 80)                         item.id_value = 32'hFFFF_FFFF;
    else                                     item.id_value = $urandom;
    if (item.id_value != '0) begin
      recent_ids.push_back(item.id_value);
      if (recent_ids.size() > 12) void'(recent_ids.pop_front());
    end
    return item;
  endfunction

  task automatic queue_command(logic [1:0] command, logic [31:0] id_value);
    in_t item;
    item.command  = command;
    item.id_value = id_value;
    pending_commands.push_back(item);
  endtask

  // Waits until every command is through and every result is back, then writes table_size.
  task automatic write_table_size(logic [TableSizeW-1:0] value);
    while (pending_commands.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    model_table_size = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Input transfer accepted: predict its result.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_results.push_back(apply_command(in_data_i));
      in_taken = 1'b1;
    end
  end

  // Command driver: holds a stalled transfer, otherwise idles or presents the next one.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        in_taken = 1'b0;
        if (in_gap_left > 0) begin
          in_gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_commands.size() > 0) begin
          in_data_i   <= pending_commands.pop_front();
          in_valid_i  <= 1'b1;
          in_gap_left = idle_length(in_idle_on);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_stall_left > 0) begin
        out_stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        out_stall_left = idle_length(out_idle_on);
      end
    end
  end

  // Result monitor: compares each output transfer with the oldest prediction.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer: %p", out_data_o);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, out_data_o.status);
          error_count++;
        end
        if (out_data_o.id_out !== want.id_out) begin
          $error("id_out mismatch: expected %h, actual %h", want.id_out, out_data_o.id_out);
          error_count++;
        end
        if (out_data_o.slot_index !== want.slot_index) begin
          $error("slot_index mismatch: expected %0d, actual %0d",
                 want.slot_index, out_data_o.slot_index);
          error_count++;
        end
        if (out_data_o.entry_count !== want.entry_count) begin
          $error("entry_count mismatch: expected %0d, actual %0d",
                 want.entry_count, out_data_o.entry_count);
          error_count++;
        end
      end
    end
  end

  // Watchdog: ends the run when work is outstanding but nothing moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (pending_commands.size() == 0 && !in_valid_i && expected_results.size() == 0)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    in_valid_i       = 1'b0;
    in_data_i        = '0;
    out_stall_i      = 1'b0;
    in_taken         = 1'b0;
    in_gap_left      = 0;
    out_stall_left   = 0;
    quiet_cycles     = 0;
    error_count      = 0;
    add_weight       = 35;
    in_idle_on       = 1'b1;
    out_idle_on      = 1'b1;
    model_count      = 0;
    model_table_size = TableSizeReset;
    for (int i = 0; i < Depth; i++) model_slots[i] = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Full window: zero IDs, absent IDs, duplicates, collisions, unknown command.
    write_table_size(5'd16);
    queue_command(CMD_REMOVE, 32'h0);
    queue_command(CMD_REMOVE, 32'h5);
    queue_command(CMD_ADD, 32'h0);
    queue_command(CMD_ALLOC, 32'h0);
    queue_command(CMD_ADD, 32'hFFFF_FFFF);
    queue_command(CMD_ADD, 32'h1);
    queue_command(CMD_ADD, 32'h1);
    queue_command(CMD_ALLOC, 32'h1);
    queue_command(CMD_ALLOC, 32'h8000_0000);
    queue_command(CmdUnknown, 32'h1);
    queue_command(CMD_REMOVE, 32'h1);
    queue_command(CMD_ADD, 32'h7);
    queue_command(CMD_REMOVE, 32'hFFFF_FFFF);

    // Two-slot window: fill it, then a present candidate in a full table collides.
    write_table_size(5'd2);
    queue_command(CMD_ADD, 32'h9);
    queue_command(CMD_ADD, 32'hA);
    queue_command(CMD_ALLOC, 32'h7);
    queue_command(CMD_ALLOC, 32'hB);
    queue_command(CMD_REMOVE, 32'h8000_0000);

    // Empty window: nothing can be stored or found.
    write_table_size(5'd0);
    queue_command(CMD_ADD, 32'h3);
    queue_command(CMD_ALLOC, 32'h3);
    queue_command(CMD_REMOVE, 32'h9);

    // Oversized setting is clipped to the full table.
    write_table_size(5'd31);
    queue_command(CMD_REMOVE, 32'h8000_0000);
    queue_command(CmdUnknown, 32'h0);

    // Random phases over several window sizes, with and without idling.
    for (int p = 0; p < RandomPhases; p++) begin
      case (p)
        0:       write_table_size(5'd1);
        1:       write_table_size(5'd16);
        2:       write_table_size(5'd31);
        3:       write_table_size(5'd0);
        default: write_table_size(TableSizeW'($urandom_range(0, 31)));
      endcase
      in_idle_on  = (p % 3) != 2;
      out_idle_on = (p % 4) != 3;
      add_weight  = (p % 2 == 0) ? 35 : 45;
      for (int n = 0; n < PhaseItems; n++) pending_commands.push_back(random_command());
    end

    while (pending_commands.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
